// ===== sv/hrc_pkg.sv =====
// shared constants and types of the hsv/rgb colour converter
package hrc_pkg;

  localparam int SEG_STEPS = 255;
  localparam logic [10:0] HUE_YEL   = 11'(1 * SEG_STEPS);
  localparam logic [10:0] HUE_GRN   = 11'(2 * SEG_STEPS);
  localparam logic [10:0] HUE_CYN   = 11'(3 * SEG_STEPS);
  localparam logic [10:0] HUE_BLU   = 11'(4 * SEG_STEPS);
  localparam logic [10:0] HUE_MAG   = 11'(5 * SEG_STEPS);
  localparam logic [10:0] HUE_WRAP  = 11'(6 * SEG_STEPS);
  localparam logic [7:0]  CHAN_FULL = 8'd255;

  localparam logic MODE_HSV = 1'b0;
  localparam logic MODE_RGB = 1'b1;

  localparam logic [1:0] SEL_RED = 2'd0;
  localparam logic [1:0] SEL_GRN = 2'd1;
  localparam logic [1:0] SEL_BLU = 2'd2;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QBITS  = 8;
  localparam int NSTG   = QBITS + 1;

  typedef struct packed {
    logic            mode;
    logic [2:0][7:0] c;
    logic [7:0]      sat;
    logic [7:0]      val;
    logic            neg;
    logic [7:0]      adiff;
    logic [7:0]      rng;
    logic [7:0]      mx;
    logic [1:0]      hsel;
  } q_item_t;

  typedef struct packed {
    logic             mode;
    logic [2:0][7:0]  c;
    logic [7:0]       sat;
    logic [7:0]       val;
    logic [2:0][15:0] acc;
    logic [2:0][7:0]  res;
    logic             neg;
    logic [1:0]       hsel;
    logic [7:0]       rng;
    logic [7:0]       mx;
    logic [15:0]      hrem;
    logic [7:0]       hq;
    logic [15:0]      srem;
    logic [7:0]       sq;
  } pipe_t;

endpackage

// ===== sv/hsv_rgb_color_converter_core.sv =====
// top level of the hsv/rgb colour converter
// Converts one colour word per clock while out_stall is low, in either direction, selected
// per word by in_req_type. The front end sorts a word combinationally into a four-word queue,
// and the back end runs nine register stages (operand products, then eight restoring-division
// stages producing one quotient bit each for hue and saturation, with the hsv scaling
// multiplies in the first two) and an output register. Sustained rate is one word per cycle
// while out_stall is low; in_stall rises only when the queue is full.
module hsv_rgb_color_converter_core import hrc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [10:0] in_hue_in,
  input  logic [7:0]  in_sat_in,
  input  logic [7:0]  in_val_in,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic [10:0] out_hue_out,
  output logic [7:0]  out_sat_out,
  output logic [7:0]  out_val_out
);

  q_item_t item, head;
  logic    full, empty, pop, push;

  assign in_stall = full;
  assign push     = in_valid && !full;

  hrc_front u_front (
    .req_type (in_req_type),
    .hue      (in_hue_in),
    .sat      (in_sat_in),
    .val      (in_val_in),
    .red      (in_red_in),
    .green    (in_green_in),
    .blue     (in_blue_in),
    .item     (item)
  );

  hrc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (item),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  hrc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .have_item (!empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red_out   (out_red_out),
    .green_out (out_green_out),
    .blue_out  (out_blue_out),
    .hue_out   (out_hue_out),
    .sat_out   (out_sat_out),
    .val_out   (out_val_out)
  );

endmodule

// ===== sv/hrc_front.sv =====
// front end: sorts an input word into ramp colour or max/min/difference terms
module hrc_front import hrc_pkg::*; (
  input  logic        req_type,
  input  logic [10:0] hue,
  input  logic [7:0]  sat,
  input  logic [7:0]  val,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  output q_item_t     item
);

  logic [7:0] r, g, b, mx, mn;
  logic [1:0] sel;
  logic [8:0] d;

  always_comb begin
    r = 8'd0;
    g = 8'd0;
    b = 8'd0;
    if (hue < HUE_GRN) begin
      if (hue < HUE_YEL) begin
        r = CHAN_FULL; g = hue[7:0];
      end else begin
        r = 8'(HUE_GRN - hue); g = CHAN_FULL;
      end
    end else if (hue < HUE_BLU) begin
      if (hue < HUE_CYN) begin
        g = CHAN_FULL; b = 8'(hue - HUE_GRN);
      end else begin
        g = 8'(HUE_BLU - hue); b = CHAN_FULL;
      end
    end else if (hue < HUE_WRAP) begin
      if (hue < HUE_MAG) begin
        b = CHAN_FULL; r = 8'(hue - HUE_BLU);
      end else begin
        b = 8'(HUE_WRAP - hue); r = CHAN_FULL;
      end
    end else begin
      r = CHAN_FULL;
    end
  end

  // red wins ties over green, green over blue
  always_comb begin
    if (red >= green && red >= blue) begin
      sel = SEL_RED; mx = red;
      d = {1'b0, green} - {1'b0, blue};
    end else if (green >= blue) begin
      sel = SEL_GRN; mx = green;
      d = {1'b0, blue} - {1'b0, red};
    end else begin
      sel = SEL_BLU; mx = blue;
      d = {1'b0, red} - {1'b0, green};
    end
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
  end

  always_comb begin
    item.mode  = req_type;
    item.c     = {b, g, r};
    item.sat   = sat;
    item.val   = val;
    item.neg   = d[8];
    item.adiff = d[8] ? 8'(-d) : d[7:0];
    item.rng   = mx - mn;
    item.mx    = mx;
    item.hsel  = sel;
  end

endmodule

// ===== sv/hrc_queue.sv =====
// short queue between front end and arithmetic back end
module hrc_queue import hrc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  input  logic    pop,
  output q_item_t head,
  output logic    full,
  output logic    empty
);

  q_item_t        mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_item;
  end

endmodule

// ===== sv/hrc_back.sv =====
// back end: pipelined scaling and one-bit-per-stage dividers, output register
module hrc_back import hrc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        have_item,
  input  q_item_t     head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic [10:0] hue_out,
  output logic [7:0]  sat_out,
  output logic [7:0]  val_out
);

  pipe_t      p_r   [NSTG];
  pipe_t      p_nxt [NSTG];
  logic [NSTG-1:0] v_r;
  logic       en;
  logic       out_valid_r;
  logic [7:0] red_r, green_r, blue_r, sat_r, val_r;
  logic [10:0] hue_r;
  logic [11:0] hs;
  logic [7:0] sat_res;

  assign en  = !(out_valid_r && out_stall);
  assign pop = en && have_item;

  function automatic pipe_t step(pipe_t x, int j);
    pipe_t       y;
    logic [16:0] m1;
    logic [24:0] m2;
    logic [15:0] th, ts;
    int          bi;
    y  = x;
    bi = QBITS - j;
    if (j == 1) begin
      for (int k = 0; k < 3; k++) begin
        m1 = 17'(x.c[k]) * (17'(x.sat) + 17'd1);
        y.acc[k] = 16'(m1 >> 8) + (16'(SEG_STEPS) - 16'(x.sat));
      end
    end
    if (j == 2) begin
      for (int k = 0; k < 3; k++) begin
        m2 = 25'(x.acc[k]) * (25'(x.val) + 25'd1);
        y.res[k] = m2[15:8];
      end
    end
    // restoring division, one quotient bit per stage
    th = 16'({8'd0, x.rng} << bi);
    ts = 16'({8'd0, x.mx} << bi);
    if (x.hrem >= th) begin
      y.hrem = x.hrem - th;
      y.hq[bi[2:0]] = 1'b1;
    end
    if (x.srem >= ts) begin
      y.srem = x.srem - ts;
      y.sq[bi[2:0]] = 1'b1;
    end
    return y;
  endfunction

  always_comb begin
    p_nxt[0]      = '0;
    p_nxt[0].mode = head.mode;
    p_nxt[0].c    = head.c;
    p_nxt[0].sat  = head.sat;
    p_nxt[0].val  = head.val;
    p_nxt[0].neg  = head.neg;
    p_nxt[0].hsel = head.hsel;
    p_nxt[0].rng  = head.rng;
    p_nxt[0].mx   = head.mx;
    p_nxt[0].hrem = 16'(16'(SEG_STEPS) * 16'(head.adiff));
    p_nxt[0].srem = 16'(16'(head.rng) * 16'd255);
    for (int j = 1; j < NSTG; j++) p_nxt[j] = step(p_r[j-1], j);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-2:0], have_item};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NSTG; j++) p_r[j] <= p_nxt[j];
    end
  end

  // hue offset by max channel, then a single wrap into range
  always_comb begin
    pipe_t z;
    logic [11:0] off, q;
    z = p_r[NSTG-1];
    case (z.hsel)
      SEL_RED: off = 12'(HUE_WRAP);
      SEL_GRN: off = 12'(HUE_GRN);
      SEL_BLU: off = 12'(HUE_BLU);
      default: off = 12'(HUE_WRAP);
    endcase
    q  = z.neg ? -12'(z.hq) : 12'(z.hq);
    hs = off + q;
    if (hs >= 12'(HUE_WRAP)) hs = hs - 12'(HUE_WRAP);
    if (z.rng == 8'd0) hs = '0;
    sat_res = (z.mx == 8'd0) ? 8'd0 : z.sq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (p_r[NSTG-1].mode == MODE_RGB) begin
        red_r   <= 8'd0;
        green_r <= 8'd0;
        blue_r  <= 8'd0;
        hue_r   <= hs[10:0];
        sat_r   <= sat_res;
        val_r   <= p_r[NSTG-1].mx;
      end else begin
        red_r   <= p_r[NSTG-1].res[0];
        green_r <= p_r[NSTG-1].res[1];
        blue_r  <= p_r[NSTG-1].res[2];
        hue_r   <= '0;
        sat_r   <= 8'd0;
        val_r   <= 8'd0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign red_out   = red_r;
  assign green_out = green_r;
  assign blue_out  = blue_r;
  assign hue_out   = hue_r;
  assign sat_out   = sat_r;
  assign val_out   = val_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(hue_r))
    else $error("result word lost under stall");
  a_hue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> hue_r < HUE_WRAP)
    else $error("hue out of range");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> have_item && !(out_valid_r && out_stall))
    else $error("pop while stalled or empty");

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench of the hsv/rgb colour converter core
module tb_top;
  import hrc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        mode;
    logic [10:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
    logic [7:0]  red;
    logic [7:0]  grn;
    logic [7:0]  blu;
  } colour_word_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  grn;
    logic [7:0]  blu;
    logic [10:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
  } colour_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_req_type = 1'b0;
  logic [10:0] in_hue_in = '0;
  logic [7:0] in_sat_in = '0, in_val_in = '0, in_red_in = '0, in_green_in = '0;
  logic [7:0] in_blue_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_red_out, out_green_out, out_blue_out, out_sat_out, out_val_out;
  logic [10:0] out_hue_out;

  colour_word_t pending_words[$];
  colour_res_t  expected_colours[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit in_taken = 1'b0;

  hsv_rgb_color_converter_core dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [7:0] scale_chan(int unsigned c, int unsigned s, int unsigned v);
    int unsigned add, acc;
    add = (SEG_STEPS - s) & 16'hFFFF;
    acc = ((c * (1 + s)) >> 8) & 16'hFFFF;
    acc = (acc + add) & 16'hFFFF;
    return 8'(((acc * (1 + v)) >> 8) & 8'hFF);
  endfunction

  function automatic colour_res_t convert_colour(colour_word_t w);
    colour_res_t o;
    int unsigned h, r, g, b;
    int sr, sg, sb, mx, mn, rng, hh;
    o = '0;
    if (w.mode == MODE_HSV) begin
      h = w.hue; r = 0; g = 0; b = 0;
      if (h < 2 * SEG_STEPS) begin
        if (h < SEG_STEPS) begin r = 255; g = h; end
        else begin r = 2 * SEG_STEPS - h; g = 255; end
      end else if (h < 4 * SEG_STEPS) begin
        if (h < 3 * SEG_STEPS) begin g = 255; b = h - 2 * SEG_STEPS; end
        else begin g = 4 * SEG_STEPS - h; b = 255; end
      end else if (h < 6 * SEG_STEPS) begin
        if (h < 5 * SEG_STEPS) begin b = 255; r = h - 4 * SEG_STEPS; end
        else begin b = 6 * SEG_STEPS - h; r = 255; end
      end else begin
        r = 255;
      end
      o.red = scale_chan(r & 8'hFF, w.sat, w.val);
      o.grn = scale_chan(g & 8'hFF, w.sat, w.val);
      o.blu = scale_chan(b & 8'hFF, w.sat, w.val);
    end else begin
      sr = w.red; sg = w.grn; sb = w.blu;
      mx = sr; mn = sr;
      if (sg > mx) mx = sg;
      if (sb > mx) mx = sb;
      if (sg < mn) mn = sg;
      if (sb < mn) mn = sb;
      rng = mx - mn;
      hh = 0;
      if (rng != 0) begin
        if (mx == sr) hh = (SEG_STEPS * (sg - sb)) / rng + 6 * SEG_STEPS;
        else if (mx == sg) hh = (SEG_STEPS * (sb - sr)) / rng + 2 * SEG_STEPS;
        else hh = (SEG_STEPS * (sr - sg)) / rng + 4 * SEG_STEPS;
        hh = hh % (6 * SEG_STEPS);
      end
      o.hue = 11'(hh);
      o.sat = (mx == 0) ? 8'd0 : 8'((rng * 255) / mx);
      o.val = 8'(mx);
    end
    return o;
  endfunction

  function automatic colour_word_t hsv_word(int h, int s, int v);
    colour_word_t w;
    w = '0; w.mode = MODE_HSV; w.hue = 11'(h); w.sat = 8'(s); w.val = 8'(v);
    // unused rgb fields carry junk; the block must ignore them
    w.red = 8'($urandom); w.grn = 8'($urandom); w.blu = 8'($urandom);
    return w;
  endfunction

  function automatic colour_word_t rgb_word(int r, int g, int b);
    colour_word_t w;
    w = '0; w.mode = MODE_RGB; w.red = 8'(r); w.grn = 8'(g); w.blu = 8'(b);
    w.hue = 11'($urandom); w.sat = 8'($urandom); w.val = 8'($urandom);
    return w;
  endfunction

  // driver: change inputs on the falling edge, a waiting word is held until taken
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid    <= 1'b1;
          in_req_type <= pending_words[0].mode;
          in_hue_in   <= pending_words[0].hue;
          in_sat_in   <= pending_words[0].sat;
          in_val_in   <= pending_words[0].val;
          in_red_in   <= pending_words[0].red;
          in_green_in <= pending_words[0].grn;
          in_blue_in  <= pending_words[0].blu;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor: both handshakes sampled on the rising edge
  always @(posedge clk) begin
    colour_res_t got, exp_c;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_red_out, out_green_out, out_blue_out, out_hue_out, out_sat_out,
                out_val_out};
        if (expected_colours.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", got);
        end else begin
          exp_c = expected_colours.pop_front();
          if (got !== exp_c) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp r%0d g%0d b%0d h%0d s%0d v%0d, ",
                        "got r%0d g%0d b%0d h%0d s%0d v%0d"},
                       exp_c.red, exp_c.grn, exp_c.blu, exp_c.hue, exp_c.sat, exp_c.val,
                       got.red, got.grn, got.blu, got.hue, got.sat, got.val);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_colours.push_back(convert_colour(pending_words.pop_front()));
      in_taken <= in_valid && !in_stall;
    end
  end

  task automatic fill_random(int n);
    int k, x;
    for (k = 0; k < n; k++) begin
      x = $urandom_range(9);
      if (x < 4) pending_words.push_back(hsv_word($urandom_range(1535), $urandom_range(255),
                                                   $urandom_range(255)));
      else if (x < 8) pending_words.push_back(rgb_word($urandom_range(255), $urandom_range(255),
                                                       $urandom_range(255)));
      else if (x == 8) pending_words.push_back(hsv_word(1530 + $urandom_range(5),
                                                        $urandom_range(1) ? 255 : 0,
                                                        $urandom_range(255)));
      else begin
        // ties and greys
        x = $urandom_range(255);
        case ($urandom_range(3))
          0: pending_words.push_back(rgb_word(x, x, x));
          1: pending_words.push_back(rgb_word(x, x, $urandom_range(255)));
          2: pending_words.push_back(rgb_word($urandom_range(255), x, x));
          default: pending_words.push_back(rgb_word(x, $urandom_range(255), x));
        endcase
      end
    end
  endtask

  task automatic drain;
    int k;
    while (pending_words.size() > 0 || expected_colours.size() > 0 || in_valid)
      @(posedge clk);
    for (k = 0; k < 30; k++) @(posedge clk);
  endtask

  initial begin
    int hues[] = '{0, 1, 254, 255, 256, 509, 510, 764, 765, 1019, 1020, 1274, 1275,
                   1529, 1530, 1535, 2047};
    foreach (hues[i]) pending_words.push_back(hsv_word(hues[i], $urandom_range(255), 255));
    pending_words.push_back(hsv_word(100, 0, 0));
    pending_words.push_back(hsv_word(100, 255, 255));
    pending_words.push_back(rgb_word(0, 0, 0));
    pending_words.push_back(rgb_word(255, 255, 255));
    pending_words.push_back(rgb_word(255, 255, 0));
    pending_words.push_back(rgb_word(0, 255, 255));
    pending_words.push_back(rgb_word(255, 0, 255));
    pending_words.push_back(rgb_word(10, 0, 255));
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 27; recv_idle_pct = 70;
    fill_random(350);
    drain();
    send_idle_pct = 70; recv_idle_pct = 27;
    fill_random(380);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    fill_random(400);
    drain();
    if (mismatches == 0 && expected_colours.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #500us;
    $display("Test completed with failures");
    $finish;
  end
endmodule

// ===== hsv_rgb_color_converter_core.f =====
sv/hrc_pkg.sv
sv/hrc_front.sv
sv/hrc_queue.sv
sv/hrc_back.sv
sv/hsv_rgb_color_converter_core.sv
verif/tb_top.sv
